### src/clsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsa_pkg
// Shared widths, register indexes and types of the closed-loop stepper axis.
// ----------------------------------------------------------------------------
package clsa_pkg;

    localparam int ANGLE_W    = 12;
    localparam int POS_W      = 32;
    localparam int WRAP_W     = 20;
    localparam int ISUM_W     = 24;
    localparam int THR_W      = 12;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int SPEED_SHIFT = 8;

    localparam int RING_DEPTH_DEF = 20;
    localparam int TICKS_DEF      = 30;
    localparam int ANGLE_BITS_DEF = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_ENABLE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_POSITION = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_LEVEL   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN      = CFG_IDX_W'(4);

    localparam logic [THR_W-1:0]  THR_RST  = THR_W'(1);
    localparam logic              FWD_RST  = 1'b1;

    // Request to push one finished interval sum into the ring.
    typedef struct packed {
        logic              push;
        logic [ISUM_W-1:0] value;
    } t_push;

    // Everything of a result except the speed, carried down the pipeline.
    typedef struct packed {
        logic             dir;
        logic             step;
        logic             issued;
        logic             arrived;
        logic [POS_W-1:0] pos;
    } t_item;

endpackage

### src/clsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module clsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/clsa_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsa_window
// Ring of interval sums with a running window sum over all ring entries.
// ----------------------------------------------------------------------------
module clsa_window #(
    parameter int RING_DEPTH = clsa_pkg::RING_DEPTH_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  clsa_pkg::t_push                                 i_push,
    output logic signed [clsa_pkg::ISUM_W+$clog2(RING_DEPTH)-1:0] o_window_sum
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int WSUM_W = clsa_pkg::ISUM_W + PTR_W;

    logic [PTR_W-1:0]                r_ptr;
    logic [PTR_W-1:0]                n_ptr;
    logic [RING_DEPTH-1:0]           r_valid;
    logic signed [WSUM_W-1:0]        r_window;
    logic signed [WSUM_W-1:0]        n_window;
    logic [clsa_pkg::ISUM_W-1:0]     rd_data;
    logic signed [clsa_pkg::ISUM_W-1:0] old_entry;

    // The read address follows the next pointer, so the entry under the
    // pointer is always waiting in the read register. A push never reads
    // the address it writes because the pointer moves on at the same edge.
    clsa_ram #(
        .WIDTH (clsa_pkg::ISUM_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_push.push),
        .i_waddr (r_ptr),
        .i_wdata (i_push.value),
        .i_raddr (n_ptr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_ptr = r_ptr;
        if (i_push.push) begin
            n_ptr = (r_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_ptr + PTR_W'(1);
        end
        // Entries never written since reset count as zero.
        old_entry = r_valid[r_ptr] ? $signed(rd_data) : '0;
        n_window  = r_window - WSUM_W'(old_entry) + WSUM_W'($signed(i_push.value));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_valid  <= '0;
            r_window <= '0;
        end else if (i_push.push) begin
            r_ptr          <= n_ptr;
            r_valid[r_ptr] <= 1'b1;
            r_window       <= n_window;
        end
    end

    assign o_window_sum = r_window;

endmodule

### src/closed_loop_stepper_axis_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closed_loop_stepper_axis_core
// Encoder unwrap, speed window and bang-bang step control for one axis.
// ----------------------------------------------------------------------------
// Usage:
// Each input item is one timer tick carrying the absolute encoder angle on
// i_encoder_angle (valid/ready). Each tick yields exactly one result item on
// the output channel: pin levels, step and arrival flags, the unwrapped
// position and the speed estimate.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while no
// item is in flight; writes take effect at once.
// The pipeline has an input register, a control stage, a ring stage, a
// multiply stage and the output register, and takes one item per cycle
// while the receiver keeps up. That rate is set by the control stage,
// where the unwrap, the interval sum and the pins close their loop.
// If the receiver stalls, items stay in the stages and the bubbles fill;
// input ready drops only when every stage holds an item.
// A synchronous reset clears the pipeline, the motion state, the pins and
// the ring (by valid bits); registers return to their reset values.
// ----------------------------------------------------------------------------
module closed_loop_stepper_axis_core #(
    parameter int RING_DEPTH         = clsa_pkg::RING_DEPTH_DEF,
    parameter int TICKS_PER_INTERVAL = clsa_pkg::TICKS_DEF,
    parameter int ANGLE_BITS         = clsa_pkg::ANGLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [clsa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [clsa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [clsa_pkg::ANGLE_W-1:0]    i_encoder_angle,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_dir_level,
    output logic                            o_step_level,
    output logic                            o_step_issued,
    output logic                            o_arrived,
    output logic signed [clsa_pkg::POS_W-1:0] o_position,
    output logic signed [clsa_pkg::POS_W-1:0] o_speed
);

    localparam int POS_W  = clsa_pkg::POS_W;
    localparam int ISUM_W = clsa_pkg::ISUM_W;
    localparam int WRAP_W = clsa_pkg::WRAP_W;
    localparam int THR_W  = clsa_pkg::THR_W;
    localparam int GAIN_W = clsa_pkg::GAIN_W;
    localparam int TICK_W = (TICKS_PER_INTERVAL > 1) ? $clog2(TICKS_PER_INTERVAL) : 1;
    localparam int WSUM_W = ISUM_W + $clog2(RING_DEPTH);
    localparam int PROD_W = WSUM_W + GAIN_W + 1;
    localparam int Q_W    = PROD_W - clsa_pkg::SPEED_SHIFT;

    localparam logic signed [ANGLE_BITS:0] HALF =
        (ANGLE_BITS + 1)'(1 << (ANGLE_BITS - 1));
    localparam logic [ISUM_W-1:0] TURN = ISUM_W'(1) << ANGLE_BITS;
    localparam logic [TICK_W-1:0] LAST_TICK = TICK_W'(TICKS_PER_INTERVAL - 1);
    localparam logic signed [Q_W-1:0] SPD_MAX = {{(Q_W - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [Q_W-1:0] SPD_MIN = {{(Q_W - 31){1'b1}}, {31{1'b0}}};

    // Configuration registers.
    logic                     r_enable;
    logic signed [POS_W-1:0]  r_target;
    logic [THR_W-1:0]         r_thr;
    logic                     r_fwd;
    logic [GAIN_W-1:0]        r_gain;

    // Motion state.
    logic [ANGLE_BITS-1:0]    r_last_enc;
    logic [WRAP_W-1:0]        r_wrap;
    logic [ISUM_W-1:0]        r_interval;
    logic [TICK_W-1:0]        r_tick;
    logic                     r_step_pin;
    logic                     r_dir_pin;

    // Pipeline.
    logic                     r_in_vld;
    logic [clsa_pkg::ANGLE_W-1:0] r_in_enc;
    logic                     r_s1_vld;
    clsa_pkg::t_item          r_s1;
    logic                     r_s1_push;
    logic [ISUM_W-1:0]        r_s1_push_val;
    logic                     r_s2_vld;
    clsa_pkg::t_item          r_s2;
    logic                     r_s3_vld;
    clsa_pkg::t_item          r_s3;
    logic signed [PROD_W-1:0] r_s3_prod;
    logic                     r_out_vld;
    clsa_pkg::t_item          r_out;
    logic signed [POS_W-1:0]  r_out_speed;

    logic adv1, adv2, adv3, adv_out;

    logic [ANGLE_BITS-1:0]        enc;
    logic signed [ANGLE_BITS:0]   diff;
    logic                         wrap_up, wrap_dn;
    logic [WRAP_W-1:0]            n_wrap;
    logic signed [POS_W-1:0]      wrap_sx;
    logic [POS_W-1:0]             pos;
    logic [ISUM_W-1:0]            delta;
    logic [ISUM_W-1:0]            interval_add;
    logic                         last_tick;
    logic [THR_W-1:0]             thr_eff;
    logic signed [POS_W:0]        err;
    logic signed [POS_W:0]        thr_s;
    logic                         go_fwd, go_rev;
    clsa_pkg::t_item              n_item;
    clsa_pkg::t_push              push_req;
    logic signed [WSUM_W-1:0]     window_sum;
    logic signed [Q_W-1:0]        spd_q;
    logic signed [POS_W-1:0]      n_speed;

    // ---------------- flow control ----------------
    assign adv_out    = r_s3_vld && (!r_out_vld || i_out_ready);
    assign adv3       = r_s2_vld && (!r_s3_vld || adv_out);
    assign adv2       = r_s1_vld && (!r_s2_vld || adv3);
    assign adv1       = r_in_vld && (!r_s1_vld || adv2);
    assign o_in_ready = !r_in_vld || adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (!r_s1_vld || adv2) begin
                r_s1_vld <= adv1;
            end
            if (!r_s2_vld || adv3) begin
                r_s2_vld <= adv2;
            end
            if (!r_s3_vld || adv_out) begin
                r_s3_vld <= adv3;
            end
            if (!r_out_vld || i_out_ready) begin
                r_out_vld <= adv_out;
            end
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_target <= '0;
            r_thr    <= clsa_pkg::THR_RST;
            r_fwd    <= clsa_pkg::FWD_RST;
            r_gain   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                clsa_pkg::CFG_AXIS_ENABLE:     r_enable <= i_cfg_data[0];
                clsa_pkg::CFG_TARGET_POSITION: r_target <= $signed(i_cfg_data[POS_W-1:0]);
                clsa_pkg::CFG_STEP_THRESHOLD:  r_thr    <= i_cfg_data[THR_W-1:0];
                clsa_pkg::CFG_FORWARD_LEVEL:   r_fwd    <= i_cfg_data[0];
                clsa_pkg::CFG_SPEED_GAIN:      r_gain   <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- control stage ----------------
    always_comb begin
        // A disabled axis replays the held angle, which yields no motion.
        enc     = r_enable ? ANGLE_BITS'(r_in_enc) : r_last_enc;
        diff    = $signed({1'b0, enc}) - $signed({1'b0, r_last_enc});
        wrap_up = diff < -HALF;
        wrap_dn = diff > HALF;
        n_wrap  = r_wrap;
        if (wrap_up) begin
            n_wrap = r_wrap + WRAP_W'(1);
        end else if (wrap_dn) begin
            n_wrap = r_wrap - WRAP_W'(1);
        end
        wrap_sx = POS_W'($signed(n_wrap));
        pos     = POS_W'(wrap_sx <<< ANGLE_BITS) | POS_W'(enc);

        // Position change is the angle change, plus or minus one turn on a wrap.
        delta = ISUM_W'(diff);
        if (wrap_up) begin
            delta = delta + TURN;
        end else if (wrap_dn) begin
            delta = delta - TURN;
        end
        interval_add = r_interval + delta;
        last_tick    = (r_tick >= LAST_TICK);

        thr_eff = (r_thr == '0) ? THR_W'(1) : r_thr;
        thr_s   = $signed({{(POS_W + 1 - THR_W){1'b0}}, thr_eff});
        err     = $signed({r_target[POS_W-1], r_target}) - $signed({pos[POS_W-1], pos});
        go_fwd  = r_enable && (err >= thr_s);
        go_rev  = r_enable && !go_fwd && (err <= -thr_s);

        n_item.dir     = go_fwd ? r_fwd : (go_rev ? !r_fwd : r_dir_pin);
        n_item.step    = r_step_pin ^ (go_fwd || go_rev);
        n_item.issued  = go_fwd || go_rev;
        n_item.arrived = !(go_fwd || go_rev);
        n_item.pos     = pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_enc <= '0;
            r_wrap     <= '0;
            r_interval <= '0;
            r_tick     <= '0;
            r_step_pin <= 1'b0;
            r_dir_pin  <= 1'b0;
        end else if (adv1 && r_enable) begin
            r_last_enc <= enc;
            r_wrap     <= n_wrap;
            r_step_pin <= n_item.step;
            r_dir_pin  <= n_item.dir;
            if (last_tick) begin
                r_interval <= '0;
                r_tick     <= '0;
            end else begin
                r_interval <= interval_add;
                r_tick     <= r_tick + TICK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_enc <= i_encoder_angle;
        end
        if (adv1) begin
            r_s1          <= n_item;
            r_s1_push     <= r_enable && last_tick;
            r_s1_push_val <= interval_add;
        end
        if (adv2) begin
            r_s2 <= r_s1;
        end
        if (adv3) begin
            r_s3      <= r_s2;
            r_s3_prod <= window_sum * $signed({1'b0, r_gain});
        end
        if (adv_out) begin
            r_out       <= r_s3;
            r_out_speed <= n_speed;
        end
    end

    // ---------------- ring stage ----------------
    always_comb begin
        push_req.push  = adv2 && r_s1_push;
        push_req.value = r_s1_push_val;
    end

    clsa_window #(
        .RING_DEPTH (RING_DEPTH)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_req),
        .o_window_sum (window_sum)
    );

    // ---------------- speed saturation ----------------
    always_comb begin
        // Arithmetic shift rounds toward minus infinity.
        spd_q = Q_W'(r_s3_prod >>> clsa_pkg::SPEED_SHIFT);
        if (spd_q > SPD_MAX) begin
            n_speed = POS_W'(SPD_MAX);
        end else if (spd_q < SPD_MIN) begin
            n_speed = POS_W'(SPD_MIN);
        end else begin
            n_speed = POS_W'(spd_q);
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_dir_level   = r_out.dir;
    assign o_step_level  = r_out.step;
    assign o_step_issued = r_out.issued;
    assign o_arrived     = r_out.arrived;
    assign o_position    = $signed(r_out.pos);
    assign o_speed       = r_out_speed;

`ifndef SYNTH
    // A tick on a disabled axis never steps.
    a_disabled_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv1 && !r_enable) |=> (!r_s1.issued && r_s1.arrived))
        else $error("disabled axis issued a step");

    // The step pin toggles exactly when the item just processed issued a step.
    a_step_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv1 |=> ((r_step_pin != $past(r_step_pin)) == r_s1.issued))
        else $error("step pin toggle does not match step flag");

    // A stalled control-stage item keeps its place and contents.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !adv2) |=> (r_s1_vld && $stable(r_s1)))
        else $error("control stage item lost while stalled");

    // The tick counter stays inside one interval.
    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv1 |=> (r_tick <= LAST_TICK))
        else $error("tick counter out of range");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the closed-loop stepper axis core. Encoder ticks go
// in over valid/ready and a scoreboard that tracks unwrap, interval ring,
// speed window and pin state predicts every result item and checks it field
// by field. Register settings change between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int ANGLE_W    = clsa_pkg::ANGLE_W;
    localparam int POS_W      = clsa_pkg::POS_W;
    localparam int THR_W      = clsa_pkg::THR_W;
    localparam int GAIN_W     = clsa_pkg::GAIN_W;
    localparam int WRAP_W     = clsa_pkg::WRAP_W;
    localparam int ISUM_W     = clsa_pkg::ISUM_W;
    localparam int CFG_IDX_W  = clsa_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = clsa_pkg::CFG_DATA_W;

    localparam int HALF_PERIOD    = 2;
    localparam int HALF_TURN      = 1 << (ANGLE_W - 1);
    localparam int RANDOM_TICKS   = 980;
    localparam int CALM_TAIL      = 150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {
        MOTION_HOLD,
        MOTION_CRAWL,
        MOTION_SLEW,
        MOTION_NOISE
    } t_motion;

    typedef struct packed {
        logic             dir;
        logic             step;
        logic             issued;
        logic             arrived;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] speed;
    } t_axis_result;

    class t_axis_scoreboard;
        // Register copies.
        logic              enable;
        logic [POS_W-1:0]  target;
        logic [THR_W-1:0]  threshold;
        logic              fwd_level;
        logic [GAIN_W-1:0] gain;
        // Motion state.
        logic [ANGLE_W-1:0] prev_angle;
        logic [WRAP_W-1:0]  turns;
        logic [POS_W-1:0]   last_pos;
        logic [ISUM_W-1:0]  interval_acc;
        int                 tick_in_interval;
        logic [ISUM_W-1:0]  interval_ring [clsa_pkg::RING_DEPTH_DEF];
        int                 ring_slot;
        longint             window;
        logic               step_pin;
        logic               dir_pin;

        t_axis_result pending[$];
        int errors = 0;
        int checked = 0;
        int ticks_enabled = 0;
        int ticks_ignored = 0;
        int steps = 0;
        int arrivals = 0;
        int wraps = 0;
        int pushes = 0;

        function new();
            enable           = 1'b0;
            target           = '0;
            threshold        = clsa_pkg::THR_RST;
            fwd_level        = clsa_pkg::FWD_RST;
            gain             = '0;
            prev_angle       = '0;
            turns            = '0;
            last_pos         = '0;
            interval_acc     = '0;
            tick_in_interval = 0;
            foreach (interval_ring[i]) interval_ring[i] = '0;
            ring_slot        = 0;
            window           = 0;
            step_pin         = 1'b0;
            dir_pin          = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                clsa_pkg::CFG_AXIS_ENABLE:     enable    = data[0];
                clsa_pkg::CFG_TARGET_POSITION: target    = data[POS_W-1:0];
                clsa_pkg::CFG_STEP_THRESHOLD:  threshold = data[THR_W-1:0];
                clsa_pkg::CFG_FORWARD_LEVEL:   fwd_level = data[0];
                clsa_pkg::CFG_SPEED_GAIN:      gain      = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Window sum times gain, floored by the Q8.8 shift, clamped to 32 bits.
        function logic [POS_W-1:0] speed_of_window();
            longint scaled;
            scaled = (window * longint'(gain)) >>> clsa_pkg::SPEED_SHIFT;
            if (scaled > 64'sd2147483647) scaled = 64'sd2147483647;
            else if (scaled < -64'sd2147483648) scaled = -64'sd2147483648;
            return scaled[POS_W-1:0];
        endfunction

        function void note_tick(logic [ANGLE_W-1:0] angle);
            t_axis_result     r;
            int               diff;
            int               slot;
            logic [POS_W-1:0] pos;
            longint           err;
            longint           thr_eff;
            r.issued  = 1'b0;
            r.arrived = 1'b1;
            if (enable) begin
                ticks_enabled++;
                diff = int'(angle) - int'(prev_angle);
                if (diff < -HALF_TURN) begin
                    turns = turns + 1'b1;
                    wraps++;
                end else if (diff > HALF_TURN) begin
                    turns = turns - 1'b1;
                    wraps++;
                end
                prev_angle = angle;
                pos = {turns, angle};
                interval_acc = interval_acc + ISUM_W'(pos - last_pos);
                last_pos = pos;

                if (tick_in_interval >= clsa_pkg::TICKS_DEF - 1) begin
                    slot = ring_slot % clsa_pkg::RING_DEPTH_DEF;
                    window = window - longint'($signed(interval_ring[slot]));
                    interval_ring[slot] = interval_acc;
                    window = window + longint'($signed(interval_acc));
                    ring_slot = (slot + 1) % clsa_pkg::RING_DEPTH_DEF;
                    tick_in_interval = 0;
                    interval_acc = '0;
                    pushes++;
                end else begin
                    tick_in_interval++;
                end

                err = longint'($signed(target)) - longint'($signed(pos));
                thr_eff = (threshold == '0) ? 64'sd1 : longint'(threshold);
                if (err >= thr_eff) begin
                    dir_pin  = fwd_level;
                    step_pin = ~step_pin;
                    r.issued = 1'b1;
                    r.arrived = 1'b0;
                end else if (err <= -thr_eff) begin
                    dir_pin  = ~fwd_level;
                    step_pin = ~step_pin;
                    r.issued = 1'b1;
                    r.arrived = 1'b0;
                end
                if (r.issued) steps++;
                else arrivals++;
            end else begin
                ticks_ignored++;
            end
            r.dir   = dir_pin;
            r.step  = step_pin;
            r.pos   = last_pos;
            r.speed = speed_of_window();
            pending.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] seen);
            if (want !== seen)
                report($sformatf("result %0d %s expected 0x%08h got 0x%08h",
                                 checked, name, want, seen));
        endtask

        task check_result(t_axis_result got);
            t_axis_result want;
            if (pending.size() == 0) begin
                report($sformatf("result %0d arrived with no tick waiting", checked));
            end else begin
                want = pending.pop_front();
                compare_field("dir_level", POS_W'(want.dir), POS_W'(got.dir));
                compare_field("step_level", POS_W'(want.step), POS_W'(got.step));
                compare_field("step_issued", POS_W'(want.issued), POS_W'(got.issued));
                compare_field("arrived", POS_W'(want.arrived), POS_W'(got.arrived));
                compare_field("position", want.pos, got.pos);
                compare_field("speed", want.speed, got.speed);
            end
            checked++;
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [ANGLE_W-1:0]    i_encoder_angle = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_dir_level;
    logic                  o_step_level;
    logic                  o_step_issued;
    logic                  o_arrived;
    logic signed [POS_W-1:0] o_position;
    logic signed [POS_W-1:0] o_speed;

    t_axis_scoreboard sb;
    bit idling = 1'b1;
    int holds_posted = 0;
    int idle_cycles = 0;

    closed_loop_stepper_axis_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_encoder_angle (i_encoder_angle),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_dir_level     (o_dir_level),
        .o_step_level    (o_step_level),
        .o_step_issued   (o_step_issued),
        .o_arrived       (o_arrived),
        .o_position      (o_position),
        .o_speed         (o_speed)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Valid stays high across back-to-back items; it only drops for a gap or a drain.
    task automatic send_tick(input logic [ANGLE_W-1:0] angle);
        int gap;
        if (idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_encoder_angle <= angle;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_tick(angle);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] en, input logic [CFG_DATA_W-1:0] tgt,
                                  input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] fwd,
                                  input logic [CFG_DATA_W-1:0] gain);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [CFG_IDX_W-1:0]  idxs [5];
        vals = '{en, tgt, thr, fwd, gain};
        idxs = '{clsa_pkg::CFG_AXIS_ENABLE, clsa_pkg::CFG_TARGET_POSITION,
                 clsa_pkg::CFG_STEP_THRESHOLD, clsa_pkg::CFG_FORWARD_LEVEL,
                 clsa_pkg::CFG_SPEED_GAIN};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.write_reg(idxs[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [ANGLE_W-1:0] next_angle(t_motion mode, logic [ANGLE_W-1:0] cur,
                                                     int heading);
        int delta;
        case (mode)
            MOTION_HOLD:  delta = int'($urandom_range(0, 6)) - 3;
            MOTION_CRAWL: delta = heading * int'($urandom_range(0, 160))
                                  + int'($urandom_range(0, 40)) - 20;
            MOTION_SLEW:  delta = heading * int'($urandom_range(1800, 2048));
            default:      return ANGLE_W'($urandom);
        endcase
        return cur + ANGLE_W'(delta);
    endfunction

    // Result side: random stalls, plus one long hold-off when requested.
    initial begin : result_sink
        int           stall_left;
        int           holds_done;
        t_axis_result got;
        stall_left = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.dir     = o_dir_level;
                got.step    = o_step_level;
                got.issued  = o_step_issued;
                got.arrived = o_arrived;
                got.pos     = o_position;
                got.speed   = o_speed;
                sb.check_result(got);
            end
            if (holds_done != holds_posted) begin
                holds_done = holds_posted;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && idling && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11);
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [ANGLE_W-1:0]    script[$];
        logic [ANGLE_W-1:0]    cur_angle;
        logic [CFG_DATA_W-1:0] en, tgt, thr, fwd, gain;
        int                    thr_eff;
        int                    heading;
        int                    phase_len;
        int                    n_phases;
        int                    random_ticks;
        bit                    near_target;
        t_motion               mode;

        sb = new();
        n_phases = 0;
        random_ticks = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset the axis is off, so these ticks must be ignored.
        send_tick(12'hFFF);
        send_tick(12'h000);
        drain();

        // Zero threshold acts as one. Exact half turns do not wrap; larger jumps do.
        apply_settings(32'd1, 32'd0, 32'd0, 32'd0, 32'h0000_FFFF);
        script = '{12'd0, 12'd2048, 12'd0, 12'd4095, 12'd0, 12'd1, 12'd4095, 12'd2049, 12'd4095};
        foreach (script[i]) send_tick(script[i]);
        drain();

        apply_settings(32'd1, 32'h7FFF_FFFF, 32'h0000_0FFF, 32'd1, 32'h0000_0180);
        script = '{12'd2048, 12'd4095, 12'd1000, 12'd3000, 12'd0};
        foreach (script[i]) send_tick(script[i]);
        drain();

        apply_settings(32'd1, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
        script = '{12'd4095, 12'd2047, 12'd0, 12'd2500};
        foreach (script[i]) send_tick(script[i]);
        drain();

        // Disabled again: pins, position and speed hold.
        apply_settings(32'd0, 32'h1234_5678, 32'd7, 32'd1, 32'h0000_8001);
        script = '{12'd100, 12'd3000};
        foreach (script[i]) send_tick(script[i]);
        cur_angle = 12'd3000;

        while (random_ticks < RANDOM_TICKS - CALM_TAIL) begin
            drain();
            n_phases++;

            en = ($urandom_range(0, 9) == 0 && n_phases != 2) ? 32'd0 : 32'd1;
            case ($urandom_range(0, 5))
                0:       thr = 32'd0;
                1:       thr = 32'd1;
                2:       thr = 32'd4095;
                default: thr = $urandom_range(2, 600);
            endcase
            thr_eff = (thr[THR_W-1:0] == '0) ? 1 : int'(thr[THR_W-1:0]);
            near_target = 1'b0;
            case ($urandom_range(0, 5))
                0:       tgt = 32'h7FFF_FFFF;
                1:       tgt = 32'h8000_0000;
                2:       tgt = $urandom;
                default: begin
                    near_target = 1'b1;
                    tgt = sb.last_pos + 32'($urandom_range(0, 2 * thr_eff)) - 32'(thr_eff);
                end
            endcase
            fwd = $urandom_range(0, 1);
            case ($urandom_range(0, 3))
                0:       gain = 32'd0;
                1:       gain = 32'h0000_FFFF;
                default: gain = $urandom_range(0, 65535);
            endcase
            // Bits above a register's width must be dropped by the core.
            if ($urandom_range(0, 3) == 0) begin
                en   = en   | ($urandom & 32'hFFFF_FFFE);
                thr  = thr  | ($urandom & 32'hFFFF_F000);
                fwd  = fwd  | ($urandom & 32'hFFFF_FFFE);
                gain = gain | ($urandom & 32'hFFFF_0000);
            end
            apply_settings(en, tgt, thr, fwd, gain);

            if (near_target && $urandom_range(0, 9) < 7) mode = MOTION_HOLD;
            else mode = t_motion'($urandom_range(0, 3));
            heading = $urandom_range(0, 1) ? 1 : -1;
            phase_len = en[0] ? $urandom_range(20, 80) : $urandom_range(3, 8);

            // Hold the result side off while ticks keep coming so the pipe backs up.
            if (n_phases == 2) begin
                mode = MOTION_CRAWL;
                holds_posted++;
            end

            for (int k = 0; k < phase_len; k++) begin
                cur_angle = next_angle(mode, cur_angle, heading);
                send_tick(cur_angle);
                if (en[0]) random_ticks++;
            end
        end

        // The last stretch is one enabled phase with no idling on either side.
        idling = 1'b0;
        drain();
        n_phases++;
        tgt  = $urandom;
        thr  = $urandom_range(1, 600);
        fwd  = $urandom_range(0, 1);
        gain = $urandom_range(0, 65535);
        apply_settings(32'd1, tgt, thr, fwd, gain);
        heading = $urandom_range(0, 1) ? 1 : -1;
        for (int k = 0; k < CALM_TAIL; k++) begin
            cur_angle = next_angle(MOTION_CRAWL, cur_angle, heading);
            send_tick(cur_angle);
            random_ticks++;
        end

        drain();
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));

        $display("Covered %0d active and %0d ignored ticks: %0d steps, %0d arrivals, %0d wraps.",
                 sb.ticks_enabled, sb.ticks_ignored, sb.steps, sb.arrivals, sb.wraps);
        $display("%0d interval sums entered the speed window over %0d phases; %0d mismatches.",
                 sb.pushes, n_phases, sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
